/* hdl/lfp_pkg.sv */
package lfp_pkg;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic parse_en;   // a byte is taken this cycle
    logic ring_upd;   // push sample, update sum/fill, load divider
    logic div_step;   // one restoring-divide step
    logic out_load;   // capture the result request
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic at_last;    // next byte is the frame's checksum byte
    logic frame_ok;   // byte on the input closes a good frame
    logic div_last;   // current divide step is the final one
  } status_t;

  // Register map
  localparam logic REG_FIRST_HDR  = 1'b0;
  localparam logic REG_SECOND_HDR = 1'b1;

  localparam logic [7:0] HDR_RESET = 8'h59;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 3;

  // Temperature offset: 256 degC in 1/8 degC units
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 17'sd2048;

endpackage

/* hdl/lfp_regs.sv */
module lfp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfp_pkg::APB_W-1:0]     pwdata,
  output logic [lfp_pkg::APB_W-1:0]     prdata,
  output logic                          pready,
  output logic [7:0]                    first_hdr,
  output logic [7:0]                    second_hdr
);

  logic [7:0] first_hdr_r;
  logic [7:0] first_hdr_nxt;
  logic [7:0] second_hdr_r;
  logic [7:0] second_hdr_nxt;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    first_hdr_nxt  = first_hdr_r;
    second_hdr_nxt = second_hdr_r;
    if (wr_en) begin
      case (reg_sel)
        lfp_pkg::REG_FIRST_HDR:  first_hdr_nxt  = pwdata[7:0];
        lfp_pkg::REG_SECOND_HDR: second_hdr_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= lfp_pkg::HDR_RESET;
      second_hdr_r <= lfp_pkg::HDR_RESET;
    end else begin
      first_hdr_r  <= first_hdr_nxt;
      second_hdr_r <= second_hdr_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      lfp_pkg::REG_FIRST_HDR:  prdata = {{(lfp_pkg::APB_W-8){1'b0}}, first_hdr_r};
      lfp_pkg::REG_SECOND_HDR: prdata = {{(lfp_pkg::APB_W-8){1'b0}}, second_hdr_r};
      default:                 prdata = '0;
    endcase
  end

  assign first_hdr  = first_hdr_r;
  assign second_hdr = second_hdr_r;

endmodule

/* hdl/lfp_ctrl.sv */
module lfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lfp_pkg::status_t  status,
  output lfp_pkg::cmd_t     cmd
);

  lfp_pkg::state_t state_r;
  lfp_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            in_take;

  // A checksum byte may only be taken once the output slot is free
  assign in_ready = (state_r == lfp_pkg::ST_IDLE) && (!status.at_last || !out_valid_r);
  assign in_take  = in_valid & in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd.parse_en = 1'b0;
    cmd.ring_upd = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      lfp_pkg::ST_IDLE: begin
        cmd.parse_en = in_take;
        if (in_take && status.frame_ok) begin
          state_nxt = lfp_pkg::ST_READ;
        end
      end
      lfp_pkg::ST_READ: begin
        state_nxt = lfp_pkg::ST_UPDATE;
      end
      lfp_pkg::ST_UPDATE: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = lfp_pkg::ST_DIV;
      end
      lfp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = lfp_pkg::ST_DONE;
        end
      end
      lfp_pkg::ST_DONE: begin
        cmd.out_load = 1'b1;
        state_nxt    = lfp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lfp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Output slot must be empty when a new result is loaded
  a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lfp_pkg::ST_DONE |-> !out_valid_r)
    else $error("result loaded over a pending one");

  // Good frame runs read then update
  a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lfp_pkg::ST_READ |=> state_r == lfp_pkg::ST_UPDATE)
    else $error("ring read not followed by update");

endmodule

/* hdl/lfp_dp.sv */
module lfp_dp #(
  parameter int unsigned FRAME_BYTES   = 9,
  parameter int unsigned AVERAGE_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfp_pkg::cmd_t                     cmd,
  output lfp_pkg::status_t                  status,
  input  logic [7:0]                        first_hdr,
  input  logic [7:0]                        second_hdr,
  input  logic [7:0]                        rx_byte,
  output logic [lfp_pkg::DATA_W-1:0]        distance_average,
  output logic [lfp_pkg::DATA_W-1:0]        distance_raw,
  output logic [lfp_pkg::DATA_W-1:0]        signal_strength,
  output logic signed [lfp_pkg::TEMP_W-1:0] temperature_eighths
);

  localparam int unsigned PW = $clog2(FRAME_BYTES);
  localparam int unsigned IW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(AVERAGE_DEPTH + 1);
  localparam int unsigned SW = lfp_pkg::DATA_W + CW;
  localparam int unsigned KW = $clog2(SW + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(FRAME_BYTES - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(AVERAGE_DEPTH - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(AVERAGE_DEPTH);

  // Frame parser
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    csum_r, csum_nxt;
  logic          hdr2_ok_r, hdr2_ok_nxt;
  logic [7:0]    fb_r [6];

  // Filter
  logic [lfp_pkg::DATA_W-1:0] ring_mem [AVERAGE_DEPTH];
  logic [lfp_pkg::DATA_W-1:0] ring_rd_r;
  logic [IW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic [lfp_pkg::DATA_W-1:0] sample;
  logic                       ring_full;

  // Divider
  logic [SW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   trial;
  logic          trial_ge;

  // Result request
  logic [lfp_pkg::DATA_W-1:0]        avg_out_r, dist_out_r, sig_out_r;
  logic signed [lfp_pkg::TEMP_W-1:0] temp_out_r;
  logic signed [lfp_pkg::TEMP_W-1:0] temp_val;

  assign status.at_last  = (pos_r == POS_LAST);
  assign status.frame_ok = (pos_r == POS_LAST) && hdr2_ok_r && (csum_r == rx_byte);
  assign status.div_last = (cnt_r == KW'(1));

  always_comb begin
    pos_nxt     = pos_r;
    csum_nxt    = csum_r;
    hdr2_ok_nxt = hdr2_ok_r;
    if (cmd.parse_en) begin
      if (pos_r == '0) begin
        if (rx_byte == first_hdr) begin
          csum_nxt = rx_byte;
          pos_nxt  = PW'(1);
        end
      end else if (pos_r != POS_LAST) begin
        if (pos_r == PW'(1)) begin
          hdr2_ok_nxt = (rx_byte == second_hdr);
        end
        csum_nxt = csum_r + rx_byte;
        pos_nxt  = pos_r + PW'(1);
      end else begin
        pos_nxt     = '0;
        csum_nxt    = '0;
        hdr2_ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      csum_r    <= '0;
      hdr2_ok_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      csum_r    <= csum_nxt;
      hdr2_ok_r <= hdr2_ok_nxt;
    end
  end

  // Field bytes 2..7
  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      if (cmd.parse_en && pos_r == PW'(k + 2)) begin
        fb_r[k] <= rx_byte;
      end
    end
  end

  assign sample    = {fb_r[1], fb_r[0]};
  assign ring_full = (fill_r == FILL_MAX);
  assign temp_val  = $signed({fb_r[5][7], fb_r[5], fb_r[4]}) - lfp_pkg::TEMP_OFFSET;

  // Ring memory: one write port, one registered read at the write slot
  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      ring_mem[idx_r] <= sample;
    end
    ring_rd_r <= ring_mem[idx_r];
  end

  assign trial    = {rem_r, quo_r[SW-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});

  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    if (cmd.ring_upd) begin
      if (ring_full) begin
        sum_nxt = sum_r - SW'(ring_rd_r) + SW'(sample);
      end else begin
        sum_nxt  = sum_r + SW'(sample);
        fill_nxt = fill_r + CW'(1);
      end
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + IW'(1);
      quo_nxt = sum_nxt;
      dvs_nxt = fill_nxt;
      rem_nxt = '0;
      cnt_nxt = KW'(SW);
    end
    if (cmd.div_step) begin
      rem_nxt = trial_ge ? CW'(trial - {1'b0, dvs_r}) : CW'(trial);
      quo_nxt = {quo_r[SW-2:0], trial_ge};
      cnt_nxt = cnt_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      idx_r  <= idx_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (cmd.out_load) begin
      avg_out_r  <= quo_r[lfp_pkg::DATA_W-1:0];
      dist_out_r <= sample;
      sig_out_r  <= {fb_r[3], fb_r[2]};
      temp_out_r <= temp_val;
    end
  end

  assign distance_average    = avg_out_r;
  assign distance_raw        = dist_out_r;
  assign signal_strength     = sig_out_r;
  assign temperature_eighths = temp_out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond ring depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("ring slot out of range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> cnt_r != '0)
    else $error("divide step with no steps left");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ring_upd && !ring_full |=> fill_r == $past(fill_r) + CW'(1))
    else $error("fill count not advanced on push");

endmodule

/* hdl/lidar_frame_parser_moving_average_top.sv */
// Serial sensor frame parser with a moving average on distance. One received
// byte is taken per request on the in_ channel. While hunting, bytes other
// than the first header are dropped; a first header opens a frame of
// FRAME_BYTES bytes whose second byte must match the second header and whose
// last byte must equal the 8-bit sum of all earlier bytes. A good frame
// produces one out_ request: distance, signal strength, temperature in
// 1/8 degC (signed raw word minus 2048) and the distance averaged over the
// last AVERAGE_DEPTH good frames (sum divided by the fill count, truncated).
// A bad frame produces nothing and leaves the filter alone. Rate: one byte
// per cycle while the input is not busy with a good frame. The checksum
// byte of a good frame keeps the input busy through the ring memory read,
// the sum update, the bit-serial restoring divider at one quotient bit per
// cycle, and the output load. Bytes are taken while an earlier result
// waits, except a checksum byte, which waits for the output register to
// drain. Headers are set through the APB port: byte address 0 first header,
// 4 second header, both reset to 0x59. Reset empties the filter.
module lidar_frame_parser_moving_average_top #(
  parameter int unsigned FRAME_BYTES   = 9,
  parameter int unsigned AVERAGE_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // received byte requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  // result requests
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfp_pkg::DATA_W-1:0]        out_distance_average,
  output logic [lfp_pkg::DATA_W-1:0]        out_distance_raw,
  output logic [lfp_pkg::DATA_W-1:0]        out_signal_strength,
  output logic signed [lfp_pkg::TEMP_W-1:0] out_temperature_eighths,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfp_pkg::PADDR_W-1:0]       paddr,
  input  logic [lfp_pkg::APB_W-1:0]         pwdata,
  output logic [lfp_pkg::APB_W-1:0]         prdata,
  output logic                              pready
);

  lfp_pkg::cmd_t    cmd;
  lfp_pkg::status_t status;
  logic [7:0]       first_hdr;
  logic [7:0]       second_hdr;

  // Header registers and read-back
  lfp_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .first_hdr  (first_hdr),
    .second_hdr (second_hdr)
  );

  // Sequencer: handshakes and frame-end steps
  lfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Parser, ring filter, divider and result registers
  lfp_dp #(
    .FRAME_BYTES   (FRAME_BYTES),
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .first_hdr           (first_hdr),
    .second_hdr          (second_hdr),
    .rx_byte             (in_rx_byte),
    .distance_average    (out_distance_average),
    .distance_raw        (out_distance_raw),
    .signal_strength     (out_signal_strength),
    .temperature_eighths (out_temperature_eighths)
  );

endmodule

/* tb/tb_lidar_frame_parser_moving_average_top.sv */
`timescale 1ns / 100ps

module tb_lidar_frame_parser_moving_average_top;

  // Frame layout and filter depth; the frame layout below assumes 9 bytes
  localparam int unsigned FRAME_BYTES   = 9;
  localparam int unsigned AVERAGE_DEPTH = 8;

  // Quiet cycles before a header write: a byte that closes no result may
  // still be in flight
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_BYTES   = 270;

  localparam logic signed [lfp_pkg::TEMP_W-1:0] TEMP_BIAS = 17'sd2048;

  // One result request
  typedef struct packed {
    logic [lfp_pkg::DATA_W-1:0]        avg;
    logic [lfp_pkg::DATA_W-1:0]        raw;
    logic [lfp_pkg::DATA_W-1:0]        sig;
    logic signed [lfp_pkg::TEMP_W-1:0] temp;
  } reading_t;

  // One directed frame, with an optional typed-in result
  typedef struct packed {
    logic [7:0]  lead;      // stray byte sent first, dropped while hunting
    logic [7:0]  hdr2;
    logic [15:0] distance;
    logic [15:0] sig;
    logic [15:0] traw;
    logic [7:0]  sum_flip;  // nonzero corrupts the checksum
    logic        pinned;
    reading_t    want;
  } frame_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [7:0]                          in_rx_byte;
  logic                                out_valid;
  logic                                out_ready;
  logic [lfp_pkg::DATA_W-1:0]          out_distance_average;
  logic [lfp_pkg::DATA_W-1:0]          out_distance_raw;
  logic [lfp_pkg::DATA_W-1:0]          out_signal_strength;
  logic signed [lfp_pkg::TEMP_W-1:0]   out_temperature_eighths;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [lfp_pkg::PADDR_W-1:0]         paddr;
  logic [lfp_pkg::APB_W-1:0]           pwdata;
  logic [lfp_pkg::APB_W-1:0]           prdata;
  logic                                pready;

  lidar_frame_parser_moving_average_top #(
    .FRAME_BYTES  (FRAME_BYTES),
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_distance_average   (out_distance_average),
    .out_distance_raw       (out_distance_raw),
    .out_signal_strength    (out_signal_strength),
    .out_temperature_eighths(out_temperature_eighths),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Header registers as the parser should currently see them
  logic [7:0]  cfg_first_hdr;
  logic [7:0]  cfg_second_hdr;

  // Parser and filter state mirrored by the predictor
  int unsigned frm_pos;
  logic [7:0]  frm_sum;
  logic        frm_hdr2_ok;
  logic [7:0]  frm_fields [6];
  logic [15:0] dist_ring [AVERAGE_DEPTH];
  int unsigned ring_wr;
  int unsigned ring_fill;
  int unsigned dist_sum;

  // Results still owed by the block, oldest first
  reading_t    pending_readings [$];
  reading_t    pinned_reading;
  logic        pin_armed;

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned rx_sent;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;

  // Directed frames, sent after reset with both headers at 0x59. The first
  // two carry every field at its top and bottom end, so the result is plain:
  // the average of 0xFFFF and 0 truncates to 0x7FFF, raw 0x7FFF gives
  // 30719 eighths and raw 0x8000 gives -34816. The last two put header
  // bytes inside the frame; one of them also fails the checksum.
  frame_row_t  directed_frames [4] = '{
    '{8'h00, 8'h59, 16'hFFFF, 16'hFFFF, 16'h7FFF, 8'h00, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd30719}},
    '{8'hFF, 8'h59, 16'h0000, 16'h0000, 16'h8000, 8'h00, 1'b1,
      '{16'h7FFF, 16'h0000, 16'h0000, -17'sd34816}},
    '{8'h5A, 8'h59, 16'h5959, 16'h5959, 16'h5959, 8'h01, 1'b0, '0},
    '{8'h58, 8'h59, 16'h5959, 16'h0159, 16'h0800, 8'h00, 1'b0, '0}
  };

  // Filter update: push one distance, return the truncated mean
  function automatic logic [15:0] push_distance(input logic [15:0] d);
    if (ring_fill < AVERAGE_DEPTH) begin
      dist_sum  = dist_sum + d;
      ring_fill = ring_fill + 1;
    end else begin
      dist_sum = dist_sum - dist_ring[ring_wr] + d;
    end
    dist_ring[ring_wr] = d;
    ring_wr = (ring_wr + 1) % AVERAGE_DEPTH;
    return 16'(dist_sum / ring_fill);
  endfunction

  // Parser step for one accepted byte; a good frame queues one reading
  function automatic void parse_rx_byte(input logic [7:0] b);
    reading_t                          r;
    logic [15:0]                       traw;
    logic signed [lfp_pkg::TEMP_W-1:0] t;
    if (frm_pos == 0) begin
      if (b == cfg_first_hdr) begin
        frm_sum = b;
        frm_pos = 1;
      end
    end else if (frm_pos < FRAME_BYTES - 1) begin
      if (frm_pos == 1)
        frm_hdr2_ok = (b == cfg_second_hdr);
      else if (frm_pos <= 7)
        frm_fields[frm_pos-2] = b;
      frm_sum = frm_sum + b;
      frm_pos = frm_pos + 1;
    end else begin
      frm_pos = 0;
      if (frm_hdr2_ok && frm_sum == b) begin
        r.raw  = {frm_fields[1], frm_fields[0]};
        r.sig  = {frm_fields[3], frm_fields[2]};
        traw   = {frm_fields[5], frm_fields[4]};
        t      = $signed(traw);
        r.temp = t - TEMP_BIAS;
        r.avg  = push_distance(r.raw);
        if (pin_armed) begin
          pending_readings.push_back(pinned_reading);
          pin_armed = 1'b0;
        end else begin
          pending_readings.push_back(r);
        end
      end
      frm_sum     = '0;
      frm_hdr2_ok = 1'b0;
    end
  endfunction

  // Offer one byte, idling at random first; called and returns at a
  // falling edge. The predictor runs at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b);
    rx_sent = rx_sent + 1;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] hdr2, input logic [15:0] distance,
                            input logic [15:0] sig, input logic [15:0] traw,
                            input logic [7:0] sum_flip);
    logic [7:0] frm [FRAME_BYTES];
    logic [7:0] csum;
    frm[0] = cfg_first_hdr;
    frm[1] = hdr2;
    frm[2] = distance[7:0];
    frm[3] = distance[15:8];
    frm[4] = sig[7:0];
    frm[5] = sig[15:8];
    frm[6] = traw[7:0];
    frm[7] = traw[15:8];
    csum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      csum = csum + frm[i];
    frm[FRAME_BYTES-1] = csum ^ sum_flip;
    for (int i = 0; i < FRAME_BYTES; i++)
      send_byte(frm[i]);
  endtask

  // APB read with a check of the header value held by the block; ends
  // with psel and penable low on the bus
  task automatic check_header(input logic idx, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $error("%s: expected %h, actual %h",
             (idx == lfp_pkg::REG_FIRST_HDR) ? "first_header_byte"
                                             : "second_header_byte",
             want, prdata[7:0]);
      fail_count = fail_count + 1;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // APB write; the mirror follows at the write edge
  task automatic set_header(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lfp_pkg::REG_FIRST_HDR)
      cfg_first_hdr = value;
    else
      cfg_second_hdr = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    check_header(idx, value);
  endtask

  // Stop offering bytes, let every owed result drain, then let the
  // datapath go quiet
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed frames with random content, mixed with frames that
  // fail a check, frames cut short and stray bytes
  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    logic [15:0] distance;
    goal = rx_sent + n_bytes;
    while (rx_sent < goal) begin
      pick = $urandom_range(99);
      distance = 16'($urandom);
      if ($urandom_range(3) == 0)
        distance = {8'h00, distance[7:0]};
      if (pick < 70) begin
        send_frame(cfg_second_hdr, distance, 16'($urandom), 16'($urandom), 8'h00);
      end else if (pick < 78) begin
        send_frame(cfg_second_hdr ^ 8'($urandom_range(255, 1)), distance,
                   16'($urandom), 16'($urandom), 8'h00);
      end else if (pick < 86) begin
        send_frame(cfg_second_hdr, distance, 16'($urandom), 16'($urandom),
                   8'($urandom_range(255, 1)));
      end else if (pick < 93) begin
        // frame cut short; the next frame's bytes finish it
        send_byte(cfg_first_hdr);
        repeat ($urandom_range(7, 1)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // Result channel backpressure
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= out_stall_pct);

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: avg %0d raw %0d sig %0d temp %0d",
               out_distance_average, out_distance_raw, out_signal_strength,
               out_temperature_eighths);
        fail_count = fail_count + 1;
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_distance_average !== exp_r.avg) begin
          $error("distance_average: expected %0d, actual %0d",
                 exp_r.avg, out_distance_average);
          fail_count = fail_count + 1;
        end
        if (out_distance_raw !== exp_r.raw) begin
          $error("distance_raw: expected %0d, actual %0d",
                 exp_r.raw, out_distance_raw);
          fail_count = fail_count + 1;
        end
        if (out_signal_strength !== exp_r.sig) begin
          $error("signal_strength: expected %0d, actual %0d",
                 exp_r.sig, out_signal_strength);
          fail_count = fail_count + 1;
        end
        if (out_temperature_eighths !== exp_r.temp) begin
          $error("temperature_eighths: expected %0d, actual %0d",
                 exp_r.temp, out_temperature_eighths);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // inputs known from time zero, reset released at a falling edge
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    fail_count     = 0;
    cycle_count    = 0;
    rx_sent        = 0;
    in_gap_pct     = 0;
    out_stall_pct  = 0;
    pin_armed      = 1'b0;
    pinned_reading = '0;

    // predictor copy of the reset state
    cfg_first_hdr  = lfp_pkg::HDR_RESET;
    cfg_second_hdr = lfp_pkg::HDR_RESET;
    frm_pos        = 0;
    frm_sum        = '0;
    frm_hdr2_ok    = 1'b0;
    ring_wr        = 0;
    ring_fill      = 0;
    dist_sum       = 0;
    foreach (frm_fields[i]) frm_fields[i] = '0;
    foreach (dist_ring[i]) dist_ring[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // six phases: idling pattern changes every two, headers at each one after the first
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          in_gap_pct    = 23;
          out_stall_pct = 50;
        end
        1: begin
          in_gap_pct    = 50;
          out_stall_pct = 23;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase

      case (phase)
        0: begin
          // reset values, then the directed frames
          check_header(lfp_pkg::REG_FIRST_HDR, lfp_pkg::HDR_RESET);
          check_header(lfp_pkg::REG_SECOND_HDR, lfp_pkg::HDR_RESET);
          foreach (directed_frames[i]) begin
            if (directed_frames[i].pinned) begin
              pinned_reading = directed_frames[i].want;
              pin_armed      = 1'b1;
            end
            send_byte(directed_frames[i].lead);
            send_frame(directed_frames[i].hdr2, directed_frames[i].distance,
                       directed_frames[i].sig, directed_frames[i].traw,
                       directed_frames[i].sum_flip);
          end
        end
        1: begin
          drain_block();
          set_header(lfp_pkg::REG_FIRST_HDR, 8'h00);
          set_header(lfp_pkg::REG_SECOND_HDR, 8'hFF);
        end
        2: begin
          drain_block();
          set_header(lfp_pkg::REG_FIRST_HDR, 8'hFF);
          set_header(lfp_pkg::REG_SECOND_HDR, 8'h00);
        end
        3: begin
          // both headers equal, away from the reset value
          drain_block();
          set_header(lfp_pkg::REG_FIRST_HDR, 8'hA5);
          set_header(lfp_pkg::REG_SECOND_HDR, 8'hA5);
        end
        default: begin
          drain_block();
          set_header(lfp_pkg::REG_FIRST_HDR, 8'($urandom_range(255)));
          set_header(lfp_pkg::REG_SECOND_HDR, 8'($urandom_range(255)));
        end
      endcase

      run_traffic(PHASE_BYTES);
    end

    drain_block();
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* lidar_frame_parser_moving_average_top.f */
hdl/lfp_pkg.sv
hdl/lfp_regs.sv
hdl/lfp_ctrl.sv
hdl/lfp_dp.sv
hdl/lidar_frame_parser_moving_average_top.sv
tb/tb_lidar_frame_parser_moving_average_top.sv
